### src/accm_pkg.sv
// shared types, constants and aes helper functions for the ccm cbc-mac core
`timescale 1ns / 1ps
`default_nettype none
package accm_pkg;

   localparam int unsigned BLOCK_BITS = 128;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_DATA   = 2'd1,
      OP_FINISH = 2'd2,
      OP_UNUSED = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      REG_KEY_HIGH   = 2'd0,
      REG_KEY_LOW    = 2'd1,
      REG_TAG_LENGTH = 2'd2,
      REG_UNUSED     = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY,
      ST_ENC,
      ST_ENC_A0,
      ST_RESULT
   } state_type;

   // what an aes pass is for
   typedef enum logic [1:0] {
      JOB_B0,
      JOB_ABSORB,
      JOB_A0
   } job_type;

   localparam logic [7:0] ADATA_FLAG = 8'h40;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits at bits 127-8i
   function automatic logic [7:0] blk_byte(input logic [127:0] s, input int i);
      return s[127 - 8 * i -: 8];
   endfunction

   // one aes round; the last round skips mixcolumns
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] r;
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++)
            t[c * 4 + i] = sbox(blk_byte(s, ((c + i) % 4) * 4 + i));
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[c * 4]; a1 = t[c * 4 + 1]; a2 = t[c * 4 + 2]; a3 = t[c * 4 + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[c * 4]     = a0 ^ all ^ xtime(a0 ^ a1);
            t[c * 4 + 1] = a1 ^ all ^ xtime(a1 ^ a2);
            t[c * 4 + 2] = a2 ^ all ^ xtime(a2 ^ a3);
            t[c * 4 + 3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = t[i];
      return r ^ rk;
   endfunction

   // next round key from the previous one
   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [3:0] clamp_nonce(input logic [3:0] n);
      return (n < 4'd7) ? 4'd7 : ((n > 4'd13) ? 4'd13 : n);
   endfunction

   function automatic logic [4:0] eff_tag(input logic [4:0] t);
      logic [4:0] v;
      v = (t < 5'd4) ? 5'd4 : ((t > 5'd16) ? 5'd16 : t);
      return {v[4:1], 1'b0};
   endfunction

   // flags byte, nonce, then counter or length field of L bytes
   function automatic logic [127:0] nonce_block(input logic [7:0] flags, input logic [103:0] nonce,
                                                input logic [3:0] n, input logic [31:0] tail);
      logic [127:0] b;
      logic [3:0] p;
      b = '0;
      b[127:120] = flags;
      for (int i = 0; i < 13; i++) begin
         p = n - 4'd1 - 4'(i);
         if (4'(i) < n) b[119 - 8 * i -: 8] = nonce[8 * p +: 8];
      end
      for (int i = 0; i < 4; i++)
         if (4'(i) < 4'd15 - n) b[8 * i +: 8] = tail[8 * i +: 8];
      return b;
   endfunction

endpackage
`default_nettype wire

### src/aes_ccm_cbc_mac_core.sv
// top level of the aes-128 ccm cbc-mac core with its iterative round unit
// usage:
//  - csr_ channel (valid/ready) writes key_high (0), key_low (1) or
//    tag_length (2); a key word write starts a key expansion, one round
//    key a cycle, during which csr_ready and req_stall hold the writer
//    and the request side off
//  - req_ channel (valid/stall) takes one word: start, data byte or finish
//  - rsp_ channel (valid/stall) returns one tag word for each finish
// sequencing:
//  - a data byte that does not close a block is taken while the core
//    stays idle, and the core is ready again in the next cycle
//  - a start with a nonzero aad or payload length, or a byte that closes
//    a block, runs one aes pass through the single shared round unit
//  - a finish runs the a0 pass, then holds the tag in the output register
//    until the receiver takes it; rsp_stall holds it there and the core
//    takes no new word meanwhile
// reset clears all control state, the cbc state, staging block, counters,
// saved nonce and tag_length to 16; round keys stay unknown until a key
// word is written
`timescale 1ns / 1ps
`default_nettype none
module aes_ccm_cbc_mac_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [1:0]   req_opcode,
   input  wire logic [39:0]  req_nonce_high,
   input  wire logic [63:0]  req_nonce_low,
   input  wire logic [3:0]   req_nonce_length,
   input  wire logic [47:0]  req_aad_length,
   input  wire logic [31:0]  req_payload_length,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_end_of_chunk,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [63:0]       rsp_tag_high,
   output logic [63:0]       rsp_tag_low,
   output logic [4:0]        rsp_tag_bytes,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [63:0]  csr_data
);
   import accm_pkg::*;

   state_type     state_ff, state_in;
   job_type       job_ff, job_in;
   logic [63:0]   key_high_ff, key_high_in, key_low_ff, key_low_in;
   logic [4:0]    tag_length_ff, tag_length_in;
   logic [127:0]  rk_ff [11];          // round key memory by round number
   logic [127:0]  rk_in;
   logic [127:0]  key_work_ff, key_work_in;
   logic [7:0]    rcon_ff, rcon_in;
   logic [3:0]    round_ff, round_in;
   logic [127:0]  aes_ff, aes_in;      // state under encryption
   logic [127:0]  mac_ff, mac_in;
   logic [127:0]  stage_ff, stage_in;
   logic [4:0]    fill_ff, fill_in;
   logic [47:0]   aad_count_ff, aad_count_in, aad_total_ff, aad_total_in;
   logic [103:0]  nonce_ff, nonce_in;
   logic [3:0]    nonce_len_ff, nonce_len_in;
   logic [127:0]  tag_ff, tag_in;
   logic [4:0]    tag_bytes_ff, tag_bytes_in;
   logic [127:0]  rk_rd;

   logic          req_take, csr_take, rsp_take;
   logic [3:0]    n_start, n_fin;
   logic [4:0]    t_eff;
   logic [7:0]    flags;
   logic [127:0]  stage_wr;
   logic [3:0]    slot;
   logic [4:0]    fill_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !req_valid;
   assign req_take  = req_valid && !req_stall;
   assign csr_take  = csr_valid && csr_ready;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign rsp_valid = (state_ff == ST_RESULT);
   assign rsp_tag_high  = tag_ff[127:64];
   assign rsp_tag_low   = tag_ff[63:0];
   assign rsp_tag_bytes = tag_bytes_ff;

   assign rk_rd = rk_ff[round_ff];
   assign n_start = clamp_nonce(req_nonce_length);
   assign n_fin   = clamp_nonce(nonce_len_ff);
   assign t_eff   = eff_tag(tag_length_ff);
   assign flags   = ((req_aad_length != '0) ? ADATA_FLAG : 8'h00)
                  + {2'b00, 3'(t_eff[4:1] - 4'd1), 3'b000}
                  + {4'h0, 4'd14 - n_start};
   assign slot      = fill_ff[3:0];
   assign fill_next = {1'b0, slot} + 5'd1;

   always_comb begin
      stage_wr = stage_ff;
      stage_wr[127 - 8 * slot -: 8] = req_data_byte;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_take && (csr_index == REG_KEY_HIGH || csr_index == REG_KEY_LOW))
               state_in = ST_KEY;
            else if (req_take) begin
               unique case (opcode_type'(req_opcode))
                  OP_START:
                     if (req_aad_length != '0 || req_payload_length != '0) state_in = ST_ENC;
                  OP_DATA:
                     if (fill_next == 5'd16 ||
                         ((aad_count_ff < aad_total_ff) ? (aad_count_ff + 48'd1 >= aad_total_ff)
                                                        : req_end_of_chunk))
                        state_in = ST_ENC;
                  OP_FINISH: state_in = ST_ENC_A0;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_KEY:    if (round_ff == 4'd10) state_in = ST_IDLE;
         ST_ENC:    if (round_ff == 4'd10) state_in = ST_IDLE;
         ST_ENC_A0: if (round_ff == 4'd10) state_in = ST_RESULT;
         ST_RESULT: if (rsp_take) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      job_in = job_ff;
      key_high_in = key_high_ff; key_low_in = key_low_ff; tag_length_in = tag_length_ff;
      key_work_in = key_work_ff; rcon_in = rcon_ff; round_in = round_ff;
      rk_in = key_work_ff;
      aes_in = aes_ff; mac_in = mac_ff; stage_in = stage_ff; fill_in = fill_ff;
      aad_count_in = aad_count_ff; aad_total_in = aad_total_ff;
      nonce_in = nonce_ff; nonce_len_in = nonce_len_ff;
      tag_in = tag_ff; tag_bytes_in = tag_bytes_ff;
      unique case (state_ff)
         ST_IDLE: begin
            round_in = 4'd0;
            if (csr_take) begin
               unique case (reg_index_type'(csr_index))
                  REG_KEY_HIGH: begin
                     key_high_in = csr_data;
                     key_work_in = {csr_data, key_low_ff};
                     rcon_in = 8'h01;
                  end
                  REG_KEY_LOW: begin
                     key_low_in = csr_data;
                     key_work_in = {key_high_ff, csr_data};
                     rcon_in = 8'h01;
                  end
                  REG_TAG_LENGTH: tag_length_in = csr_data[4:0];
                  default: ;
               endcase
            end else if (req_take) begin
               unique case (opcode_type'(req_opcode))
                  OP_START: if (req_aad_length != '0 || req_payload_length != '0) begin
                     job_in = JOB_B0;
                     nonce_in = {req_nonce_high, req_nonce_low};
                     nonce_len_in = n_start;
                     aad_total_in = req_aad_length;
                     aad_count_in = '0;
                     aes_in = nonce_block(flags, {req_nonce_high, req_nonce_low}, n_start,
                                          req_payload_length);
                     stage_in = '0; fill_in = '0;
                     if (req_aad_length != '0) begin
                        if (req_aad_length < 48'hff00) begin
                           stage_in[127:112] = req_aad_length[15:0];
                           fill_in = 5'd2;
                        end else if (req_aad_length[47:32] == '0) begin
                           stage_in[127:80] = {16'hfffe, req_aad_length[31:0]};
                           fill_in = 5'd6;
                        end else begin
                           stage_in[127:48] = {16'hffff, 16'h0000, req_aad_length};
                           fill_in = 5'd10;
                        end
                     end
                  end
                  OP_DATA: begin
                     job_in = JOB_ABSORB;
                     stage_in = stage_wr;
                     fill_in = fill_next;
                     aes_in = mac_ff ^ stage_wr;
                     if (aad_count_ff < aad_total_ff) aad_count_in = aad_count_ff + 48'd1;
                  end
                  OP_FINISH: begin
                     job_in = JOB_A0;
                     aes_in = nonce_block({4'h0, 4'd14 - n_fin}, nonce_ff, n_fin, 32'd0);
                     tag_bytes_in = t_eff;
                  end
                  default: ;
               endcase
            end
         end
         ST_KEY: begin
            round_in = round_ff + 4'd1;
            key_work_in = key_step(key_work_ff, rcon_ff);
            rcon_in = xtime(rcon_ff);
         end
         ST_ENC, ST_ENC_A0: begin
            round_in = round_ff + 4'd1;
            if (round_ff == 4'd0) aes_in = aes_ff ^ rk_rd;
            else aes_in = aes_round(aes_ff, rk_rd, round_ff == 4'd10);
            if (round_ff == 4'd10) begin
               unique case (job_ff)
                  JOB_B0: mac_in = aes_in;
                  JOB_ABSORB: begin
                     mac_in = aes_in; stage_in = '0; fill_in = '0;
                  end
                  default: begin
                     for (int i = 0; i < 16; i++)
                        tag_in[127 - 8 * i -: 8] = (5'(i) < tag_bytes_ff)
                           ? (mac_ff[127 - 8 * i -: 8] ^ aes_in[127 - 8 * i -: 8]) : 8'h00;
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff <= JOB_B0;
         key_high_ff <= '0; key_low_ff <= '0; tag_length_ff <= 5'd16;
         round_ff <= '0; rcon_ff <= 8'h01;
         mac_ff <= '0; stage_ff <= '0; fill_ff <= '0;
         aad_count_ff <= '0; aad_total_ff <= '0;
         nonce_ff <= '0; nonce_len_ff <= '0;
      end else begin
         state_ff <= state_in;
         job_ff <= job_in;
         key_high_ff <= key_high_in; key_low_ff <= key_low_in; tag_length_ff <= tag_length_in;
         round_ff <= round_in; rcon_ff <= rcon_in;
         mac_ff <= mac_in; stage_ff <= stage_in; fill_ff <= fill_in;
         aad_count_ff <= aad_count_in; aad_total_ff <= aad_total_in;
         nonce_ff <= nonce_in; nonce_len_ff <= nonce_len_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_work_ff <= key_work_in;
      aes_ff <= aes_in;
      tag_ff <= tag_in;
      tag_bytes_ff <= tag_bytes_in;
      if (state_ff == ST_KEY) rk_ff[round_ff] <= rk_in;
   end

endmodule
`default_nettype wire

### src/accm_checker.sv
// port-level checks for the ccm cbc-mac core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module accm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_opcode,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [4:0]  rsp_tag_bytes,
   input wire logic [63:0] rsp_tag_high,
   input wire logic        csr_valid,
   input wire logic        csr_ready
);
   import accm_pkg::*;

   // a result waiting holds the request side off
   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while tag pending");

   // tag length is always even and in range
   a_tag_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tag_bytes[0] == 1'b0 && rsp_tag_bytes >= 5'd4 && rsp_tag_bytes <= 5'd16))
      else $error("bad tag length");

   // a non-finish word never produces a result in the next cycle
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode != OP_FINISH) |=> !rsp_valid)
      else $error("unexpected result");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_tag_high)))
      else $error("stalled tag changed");

endmodule

bind aes_ccm_cbc_mac_core accm_checker u_accm_checker (.*);
`default_nettype wire

### sim/ccm_tag_checker.sv
// checker for the ccm cbc-mac core: own tag predictor and in-order tag compare
`timescale 1ns / 1ps
`default_nettype none
module ccm_tag_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire logic [1:0]   req_opcode,
   input  wire logic [39:0]  req_nonce_high,
   input  wire logic [63:0]  req_nonce_low,
   input  wire logic [3:0]   req_nonce_length,
   input  wire logic [47:0]  req_aad_length,
   input  wire logic [31:0]  req_payload_length,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_end_of_chunk,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire logic [63:0]  rsp_tag_high,
   input  wire logic [63:0]  rsp_tag_low,
   input  wire logic [4:0]   rsp_tag_bytes,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [63:0]  csr_data,
   output int                errors,
   output int                tags_pending,
   output int                tags_seen
);
   import accm_pkg::*;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
      logic [4:0]  nbytes;
   } tag_word_type;

   tag_word_type tag_queue [$];

   logic [7:0]   sub_table [256];
   logic [63:0]  key_hi, key_lo;
   logic [4:0]   tag_len_reg;
   logic [7:0]   cbc [16];
   logic [7:0]   stage [16];
   int unsigned  fill;
   logic [47:0]  aad_seen, aad_want;
   logic [103:0] nonce_reg;
   logic [3:0]   nonce_len_reg;
   logic [7:0]   rkeys [11][16];

   function automatic logic [7:0] gmul2(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // builds the s-box from gf(2^8) inverse and affine map
   function automatic void build_table();
      logic [7:0] p, q, x;
      p = 8'd1; q = 8'd1;
      sub_table[0] = 8'h63;
      do begin
         p = p ^ gmul2(p);
         q = q ^ (q << 1); q = q ^ (q << 2); q = q ^ (q << 4);
         if (q[7]) q = q ^ 8'h09;
         x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
             ^ {q[3:0], q[7:4]};
         sub_table[p] = x ^ 8'h63;
      end while (p != 8'd1);
   endfunction

   function automatic void expand();
      logic [7:0] w [176];
      logic [7:0] t [4];
      logic [7:0] tmp, rc;
      rc = 8'd1;
      for (int i = 0; i < 8; i++) begin
         w[i] = key_hi[63 - 8 * i -: 8];
         w[8 + i] = key_lo[63 - 8 * i -: 8];
      end
      for (int i = 4; i < 44; i++) begin
         for (int j = 0; j < 4; j++) t[j] = w[(i - 1) * 4 + j];
         if (i % 4 == 0) begin
            tmp = t[0];
            t[0] = sub_table[t[1]] ^ rc;
            t[1] = sub_table[t[2]];
            t[2] = sub_table[t[3]];
            t[3] = sub_table[tmp];
            rc = gmul2(rc);
         end
         for (int j = 0; j < 4; j++) w[i * 4 + j] = w[(i - 4) * 4 + j] ^ t[j];
      end
      for (int r = 0; r < 11; r++)
         for (int i = 0; i < 16; i++) rkeys[r][i] = w[16 * r + i];
   endfunction

   function automatic void encrypt(ref logic [7:0] s [16]);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      for (int i = 0; i < 16; i++) s[i] ^= rkeys[0][i];
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
               t[c * 4 + i] = sub_table[s[((c + i) % 4) * 4 + i]];
         if (r != 10)
            for (int c = 0; c < 4; c++) begin
               a0 = t[c * 4]; a1 = t[c * 4 + 1]; a2 = t[c * 4 + 2]; a3 = t[c * 4 + 3];
               all = a0 ^ a1 ^ a2 ^ a3;
               t[c * 4]     = a0 ^ all ^ gmul2(a0 ^ a1);
               t[c * 4 + 1] = a1 ^ all ^ gmul2(a1 ^ a2);
               t[c * 4 + 2] = a2 ^ all ^ gmul2(a2 ^ a3);
               t[c * 4 + 3] = a3 ^ all ^ gmul2(a3 ^ a0);
            end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ rkeys[r][i];
      end
   endfunction

   function automatic logic [3:0] nonce_clamped(input logic [3:0] n);
      return n < 7 ? 4'd7 : (n > 13 ? 4'd13 : n);
   endfunction

   function automatic logic [4:0] tag_effective();
      logic [4:0] t;
      t = tag_len_reg < 4 ? 5'd4 : (tag_len_reg > 16 ? 5'd16 : tag_len_reg);
      return {t[4:1], 1'b0};
   endfunction

   function automatic void put_nonce(ref logic [7:0] b [16], input logic [3:0] n);
      for (int i = 0; i < n; i++) b[1 + i] = nonce_reg[8 * (n - 1 - i) +: 8];
   endfunction

   function automatic void absorb();
      for (int i = 0; i < 16; i++) cbc[i] ^= stage[i];
      encrypt(cbc);
      for (int i = 0; i < 16; i++) stage[i] = 8'h00;
      fill = 0;
   endfunction

   function automatic void mac_step(input logic [1:0] op, input logic [103:0] nonce,
         input logic [3:0] nlen, input logic [47:0] aad, input logic [31:0] plen,
         input logic [7:0] dbyte, input logic eoc);
      logic [7:0] b [16];
      logic [3:0] n, ell;
      tag_word_type w;
      for (int i = 0; i < 16; i++) b[i] = 8'h00;
      case (op)
         OP_START: begin
            if (aad == 0 && plen == 0) return;
            nonce_reg = nonce;
            n = nonce_clamped(nlen);
            nonce_len_reg = n;
            ell = 4'd15 - n;
            aad_want = aad; aad_seen = 0; fill = 0;
            for (int i = 0; i < 16; i++) stage[i] = 8'h00;
            b[0] = (aad != 0 ? 8'h40 : 8'h00) + 8'((tag_effective() - 2) / 2 * 8)
                   + 8'(ell - 1);
            put_nonce(b, n);
            for (int i = 0; i < ell; i++) b[15 - i] = i < 4 ? plen[8 * i +: 8] : 8'h00;
            encrypt(b);
            cbc = b;
            if (aad != 0) begin
               if (aad < 48'hff00) begin
                  stage[0] = aad[15:8]; stage[1] = aad[7:0]; fill = 2;
               end else if (aad < 48'h1_0000_0000) begin
                  stage[0] = 8'hff; stage[1] = 8'hfe;
                  for (int i = 0; i < 4; i++) stage[2 + i] = aad[31 - 8 * i -: 8];
                  fill = 6;
               end else begin
                  stage[0] = 8'hff; stage[1] = 8'hff;
                  stage[2] = 8'h00; stage[3] = 8'h00;
                  for (int i = 0; i < 6; i++) stage[4 + i] = aad[47 - 8 * i -: 8];
                  fill = 10;
               end
            end
         end
         OP_DATA: begin
            stage[fill % 16] = dbyte;
            fill = fill % 16 + 1;
            if (aad_seen < aad_want) begin
               aad_seen++;
               if (fill == 16 || aad_seen >= aad_want) absorb();
            end else if (fill == 16 || eoc) absorb();
         end
         OP_FINISH: begin
            n = nonce_clamped(nonce_len_reg);
            b[0] = 8'(14 - n);
            put_nonce(b, n);
            encrypt(b);
            w.nbytes = tag_effective();
            w.hi = '0; w.lo = '0;
            for (int i = 0; i < 16; i++)
               if (i < w.nbytes) begin
                  if (i < 8) w.hi[63 - 8 * i -: 8] = cbc[i] ^ b[i];
                  else w.lo[63 - 8 * (i - 8) -: 8] = cbc[i] ^ b[i];
               end
            tag_queue.push_back(w);
         end
         default: ;
      endcase
   endfunction

   initial begin
      tags_pending = 0;
      build_table();
   end

   always @(posedge clock) begin
      tag_word_type want;
      if (reset) begin
         key_hi = '0; key_lo = '0;
         tag_len_reg = 5'd16;
         for (int i = 0; i < 16; i++) begin
            cbc[i] = 8'h00; stage[i] = 8'h00;
         end
         fill = 0; aad_seen = 0; aad_want = 0;
         nonce_reg = '0; nonce_len_reg = '0;
         errors = 0; tags_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_KEY_HIGH: begin key_hi = csr_data; expand(); end
               REG_KEY_LOW: begin key_lo = csr_data; expand(); end
               REG_TAG_LENGTH: tag_len_reg = csr_data[4:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            mac_step(req_opcode, {req_nonce_high, req_nonce_low}, req_nonce_length,
                     req_aad_length, req_payload_length, req_data_byte, req_end_of_chunk);
         if (rsp_valid && !rsp_stall) begin
            tags_seen++;
            if (tag_queue.size() == 0) begin
               $error("tag word with nothing expected");
               errors++;
            end else begin
               want = tag_queue.pop_front();
               if (rsp_tag_high !== want.hi) begin
                  $error("tag_high expected %h actual %h", want.hi, rsp_tag_high);
                  errors++;
               end
               if (rsp_tag_low !== want.lo) begin
                  $error("tag_low expected %h actual %h", want.lo, rsp_tag_low);
                  errors++;
               end
               if (rsp_tag_bytes !== want.nbytes) begin
                  $error("tag_bytes expected %0d actual %0d", want.nbytes, rsp_tag_bytes);
                  errors++;
               end
            end
         end
      end
      tags_pending = tag_queue.size();
   end

endmodule
`default_nettype wire

### sim/testbench.sv
// stimulus and verdict for the ccm cbc-mac core, checked by ccm_tag_checker
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import accm_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   logic [1:0]   req_opcode;
   logic [39:0]  req_nonce_high;
   logic [63:0]  req_nonce_low;
   logic [3:0]   req_nonce_length;
   logic [47:0]  req_aad_length;
   logic [31:0]  req_payload_length;
   logic [7:0]   req_data_byte;
   logic         req_end_of_chunk;
   logic         rsp_valid;
   logic         rsp_stall;
   logic [63:0]  rsp_tag_high;
   logic [63:0]  rsp_tag_low;
   logic [4:0]   rsp_tag_bytes;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [63:0]  csr_data;
   int           errors, tags_pending, tags_seen;

   int           words_sent;
   bit           gaps_on;      // idling on both sides, off for a quiet stretch
   bit           hold_off;     // long receiver hold-off to fill the core up

   aes_ccm_cbc_mac_core dut (.*);

   ccm_tag_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // generous fixed limit: ~1800 words plus stalls
   initial begin
      #20ms;
      $display("testbench: done, errors");
      $finish;
   end

   // receiver: random stall, plus a long counted hold-off when asked
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b1;
      else if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= gaps_on ? ($urandom_range(99) < 37) : 1'b0;
   end

   // one request word; random gaps before it, payload held while stalled
   task automatic send_word(input opcode_type op, input logic [103:0] nonce,
                            input logic [3:0] nlen, input logic [47:0] aad,
                            input logic [31:0] plen, input logic [7:0] dbyte,
                            input logic eoc);
      while (gaps_on && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_nonce_high <= nonce[103:64];
      req_nonce_low <= nonce[63:0];
      req_nonce_length <= nlen;
      req_aad_length <= aad;
      req_payload_length <= plen;
      req_data_byte <= dbyte;
      req_end_of_chunk <= eoc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every expected tag, then past the longest aes pass
   task automatic drain();
      release_req();
      while (tags_pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [103:0] rand_nonce();
      logic [127:0] r;
      r = {$urandom, $urandom, $urandom, $urandom};
      return r[103:0];
   endfunction

   function automatic logic [47:0] rand_wide48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[47:0];
   endfunction

   // well-formed message: start, aad bytes, payload with end marks, finish
   task automatic send_message(input int aad_n, input int pay_n);
      logic [3:0] nlen;
      nlen = 4'($urandom_range(7, 13));
      send_word(OP_START, rand_nonce(), nlen, 48'(aad_n), 32'(pay_n), 8'h00, 1'b0);
      for (int i = 0; i < aad_n; i++)
         send_word(OP_DATA, '0, '0, '0, '0, 8'($urandom), 1'($urandom_range(9) == 0));
      for (int i = 0; i < pay_n; i++)
         send_word(OP_DATA, '0, '0, '0, '0, 8'($urandom),
                   (i == pay_n - 1) || ($urandom_range(19) == 0));
      send_word(OP_FINISH, rand_nonce(), '0, '0, '0, '0, 1'b0);
   endtask

   // noise word: any opcode, any field values
   task automatic send_noise();
      send_word(opcode_type'(2'($urandom_range(3))), rand_nonce(), 4'($urandom),
                $urandom_range(1) ? rand_wide48() : 48'($urandom_range(3)),
                $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(3)),
                8'($urandom), 1'($urandom));
   endtask

   initial begin
      int msgs;
      reset = 1'b1;
      req_valid = 1'b0; req_opcode = OP_START;
      req_nonce_high = '0; req_nonce_low = '0; req_nonce_length = '0;
      req_aad_length = '0; req_payload_length = '0; req_data_byte = '0;
      req_end_of_chunk = 1'b0;
      csr_valid = 1'b0; csr_index = REG_KEY_HIGH; csr_data = '0;
      gaps_on = 1'b1; hold_off = 1'b0; words_sent = 0;
      msgs = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: the standard ccm example key, then field extremes
      write_reg(REG_KEY_HIGH, 64'h4041424344454647);
      write_reg(REG_KEY_LOW, 64'h48494a4b4c4d4e4f);
      write_reg(REG_TAG_LENGTH, 64'd4);
      send_message(8, 4);
      // empty start is ignored, finish then uses the previous nonce
      send_word(OP_START, '1, 4'd13, '0, '0, 8'h00, 1'b0);
      send_word(OP_FINISH, '0, '0, '0, '0, 8'h00, 1'b0);
      // unused opcode and nonce lengths out of range, clamped
      send_word(OP_UNUSED, '1, '1, '1, '1, 8'hff, 1'b1);
      send_word(OP_START, '1, 4'd15, '0, 32'hffff_ffff, 8'h00, 1'b0);
      send_word(OP_DATA, '0, '0, '0, '0, 8'hff, 1'b1);
      send_word(OP_FINISH, '0, '0, '0, '0, 8'h00, 1'b0);
      send_word(OP_START, '0, 4'd0, 48'd1, '0, 8'h00, 1'b0);
      // end mark during aad is ignored
      send_word(OP_DATA, '0, '0, '0, '0, 8'h00, 1'b1);
      send_word(OP_FINISH, '0, '0, '0, '0, 8'h00, 1'b0);
      // six-byte and ten-byte aad length prefixes, largest aad count
      send_word(OP_START, '1, 4'd7, 48'hff00, '0, 8'h00, 1'b0);
      send_word(OP_DATA, '0, '0, '0, '0, 8'h5a, 1'b0);
      send_word(OP_FINISH, '0, '0, '0, '0, 8'h00, 1'b0);
      send_word(OP_START, '1, 4'd13, 48'hffff_ffff_ffff, '1, 8'h00, 1'b0);
      send_word(OP_DATA, '0, '0, '0, '0, 8'ha5, 1'b1);
      send_word(OP_FINISH, '0, '0, '0, '0, 8'h00, 1'b0);
      drain();

      // random phases over several key and tag length settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_reg(REG_KEY_HIGH, '0); write_reg(REG_KEY_LOW, '0); end
            1: begin write_reg(REG_KEY_HIGH, '1); write_reg(REG_KEY_LOW, '1); end
            default: begin
               write_reg(REG_KEY_HIGH, {$urandom, $urandom});
               write_reg(REG_KEY_LOW, {$urandom, $urandom});
            end
         endcase
         // odd and out-of-range lengths get clamped and rounded down
         write_reg(REG_TAG_LENGTH, phase == 0 ? 64'd16 : phase == 1 ? 64'd31 :
                   64'($urandom_range(31)));
         write_reg(REG_UNUSED, {$urandom, $urandom});
         gaps_on = (phase != 2);   // quiet stretch with no idling
         while (words_sent < 300 * (phase + 1) + 20) begin
            msgs++;
            if (phase == 3 && msgs % 7 == 0) begin
               // burst of finishes with the receiver held off
               fork
                  begin
                     hold_off = 1'b1;
                     repeat (400) @(posedge clock);
                     hold_off = 1'b0;
                  end
                  repeat (6) send_word(OP_FINISH, '0, '0, '0, '0, 8'h00, 1'b0);
               join
            end else if ($urandom_range(9) == 0) begin
               repeat ($urandom_range(1, 4)) send_noise();
            end else begin
               send_message($urandom_range(4) == 0 ? $urandom_range(0, 40) :
                            $urandom_range(0, 3),
                            $urandom_range(9) == 0 ? $urandom_range(17, 48) :
                            $urandom_range(0, 20));
            end
         end
         drain();
      end

      $display("sent %0d request words, %0d tags compared over six key settings",
               words_sent, tags_seen);
      $display("covered aad prefixes of 2, 6 and 10 bytes, noise and receiver hold-off");
      if (errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
`default_nettype wire
